// ===== src/rmms_pkg.sv =====
// Shared types and codes for the running statistics block.
`timescale 1ns / 1ps
package rmms_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
  localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;

  // float unit operations
  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_SQRT = 3'd4;
  localparam logic [2:0] OP_ITOF = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [32:0] ival;
  } fpu_req_t;

  typedef struct packed {
    logic        finite;
    logic [31:0] bits;
  } smp_t;

endpackage

// ===== src/rmms_front.sv =====
// Input side: takes sample beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module rmms_front import rmms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  output logic        q_valid,
  output smp_t        q_item,
  input  logic        q_pop
);

  smp_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rp];
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        slots[wp].finite <= (sample_bits[30:23] != 8'hFF);
        slots[wp].bits   <= sample_bits;
        wp               <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/rmms_fpu.sv =====
// Shared binary32 unit: multiply, add, subtract, divide, square root and integer convert.
`timescale 1ns / 1ps
module rmms_fpu import rmms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  fpu_req_t    req,
  output logic        done,
  output logic [31:0] result
);

  typedef struct packed {
    logic [9:0]  e;
    logic [23:0] m;
  } unp_t;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_NORM = 2'd2;
  localparam logic [1:0] S_RND  = 2'd3;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [4:0] sh);
    logic [53:0] t;
    t = {m, 27'b0} >> sh;
    return {t[53:28], t[27] | (|t[26:0])};
  endfunction

  function automatic unp_t unpack(input logic [31:0] x);
    unp_t       u;
    logic [4:0] lz;
    lz = lzc24({1'b0, x[22:0]});
    if (x[30:23] == 8'd0) begin
      u.m = {1'b0, x[22:0]} << lz;
      u.e = 10'd1 - {5'd0, lz};
    end else begin
      u.m = {1'b1, x[22:0]};
      u.e = {2'b0, x[30:23]};
    end
    return u;
  endfunction

  function automatic logic [31:0] fp_round(input logic s, input logic signed [9:0] e,
                                           input logic [26:0] m);
    logic signed [9:0] sh_full;
    logic [4:0]        sh;
    logic [26:0]       ms;
    logic [9:0]        ee;
    logic              up;
    logic [32:0]       w;
    if (e < 10'sd1) begin
      sh_full = 10'sd1 - e;
      sh      = (sh_full > 10'sd27) ? 5'd27 : sh_full[4:0];
      ms      = shr_sticky(m, sh);
      ee      = 10'd0;
    end else begin
      sh_full = 10'sd0;
      sh      = 5'd0;
      ms      = m;
      ee      = e;
    end
    up = ms[2] & (ms[1] | ms[0] | ms[3]);
    w  = {ee, ms[25:3]} + {32'd0, up};
    if (w[32:23] >= 10'd255) begin
      return {s, 8'hFF, 23'd0};
    end
    return {s, w[30:0]};
  endfunction

  logic [1:0]        state;
  logic [2:0]        op_r;
  logic              sgn;
  logic signed [9:0] ex;
  logic [26:0]       man;
  logic              spec;
  logic [31:0]       spec_val;
  logic [29:0]       rem;
  logic [26:0]       quo;
  logic [23:0]       dvs;
  logic [53:0]       rad;
  logic [32:0]       ival;
  logic [4:0]        cnt;

  logic [31:0]       a_op, b_op, big, sml;
  unp_t              ua, ub;
  logic              nan_a, nan_b, inf_a, inf_b, z_a, z_b, sgn_x;
  logic [47:0]       prod;
  logic              a_big;
  logic [7:0]        e_big, e_sml, dexp;
  logic [26:0]       al;
  logic [27:0]       abig, sum;
  logic              spec_n;
  logic [31:0]       spec_v;
  logic              div_lt;
  logic signed [9:0] e_mul, e_div, unb, e_sq;
  logic [24:0]       sq_m;
  logic [29:0]       rsub, rem2, trial, sdiff;
  logic [4:0]        lz;

  always_comb begin
    a_op   = req.a;
    b_op   = (req.op == OP_SUB) ? {~req.b[31], req.b[30:0]} : req.b;
    ua     = unpack(a_op);
    ub     = unpack(b_op);
    nan_a  = (&a_op[30:23]) && (|a_op[22:0]);
    nan_b  = (&b_op[30:23]) && (|b_op[22:0]);
    inf_a  = (&a_op[30:23]) && !(|a_op[22:0]);
    inf_b  = (&b_op[30:23]) && !(|b_op[22:0]);
    z_a    = ~|a_op[30:0];
    z_b    = ~|b_op[30:0];
    sgn_x  = a_op[31] ^ b_op[31];
    prod   = ua.m * ub.m;

    // align the smaller magnitude under the larger one
    a_big  = (a_op[30:0] >= b_op[30:0]);
    big    = a_big ? a_op : b_op;
    sml    = a_big ? b_op : a_op;
    e_big  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dexp   = e_big - e_sml;
    al     = shr_sticky({(sml[30:23] != 8'd0), sml[22:0], 3'b000},
                        (dexp > 8'd27) ? 5'd27 : dexp[4:0]);
    abig   = {1'b0, (big[30:23] != 8'd0), big[22:0], 3'b000};
    sum    = (big[31] ^ sml[31]) ? (abig - {1'b0, al}) : (abig + {1'b0, al});

    div_lt = (ua.m < ub.m);
    e_mul  = $signed(ua.e) + $signed(ub.e) - 10'sd127;
    e_div  = $signed(ua.e) - $signed(ub.e) + 10'sd127 - (div_lt ? 10'sd1 : 10'sd0);
    unb    = $signed(ua.e) - 10'sd127;
    sq_m   = unb[0] ? {ua.m, 1'b0} : {1'b0, ua.m};
    e_sq   = ((unb - (unb[0] ? 10'sd1 : 10'sd0)) >>> 1) + 10'sd127;

    spec_n = 1'b0;
    spec_v = QNAN_BITS;
    case (req.op)
      OP_MUL: begin
        if (nan_a || nan_b || (inf_a && z_b) || (z_a && inf_b)) begin
          spec_n = 1'b1;
        end else if (inf_a || inf_b) begin
          spec_n = 1'b1;
          spec_v = {sgn_x, 8'hFF, 23'd0};
        end else if (z_a || z_b) begin
          spec_n = 1'b1;
          spec_v = {sgn_x, 31'd0};
        end
      end
      OP_ADD, OP_SUB: begin
        spec_n = 1'b1;
        if (nan_a || nan_b || (inf_a && inf_b && sgn_x)) begin
          spec_v = QNAN_BITS;
        end else if (inf_a) begin
          spec_v = a_op;
        end else if (inf_b) begin
          spec_v = b_op;
        end else if (z_a && z_b) begin
          spec_v = {a_op[31] & b_op[31], 31'd0};
        end else if (z_a) begin
          spec_v = b_op;
        end else if (z_b) begin
          spec_v = a_op;
        end else if (sum == 28'd0) begin
          spec_v = 32'd0;
        end else begin
          spec_n = 1'b0;
        end
      end
      OP_DIV: begin
        if (nan_a || nan_b || (z_a && z_b) || (inf_a && inf_b)) begin
          spec_n = 1'b1;
        end else if (inf_a || z_b) begin
          spec_n = 1'b1;
          spec_v = {sgn_x, 8'hFF, 23'd0};
        end else if (z_a || inf_b) begin
          spec_n = 1'b1;
          spec_v = {sgn_x, 31'd0};
        end
      end
      OP_SQRT: begin
        if (nan_a || (a_op[31] && !z_a)) begin
          spec_n = 1'b1;
        end else if (inf_a || z_a) begin
          spec_n = 1'b1;
          spec_v = a_op;
        end
      end
      OP_ITOF: begin
        if (req.ival == 33'd0) begin
          spec_n = 1'b1;
          spec_v = 32'd0;
        end
      end
      default: spec_n = 1'b1;
    endcase

    rsub  = rem - {6'd0, dvs};
    rem2  = {rem[27:0], rad[53:52]};
    trial = {1'b0, quo, 2'b01};
    sdiff = rem2 - trial;
    lz    = lzc27(rem[26:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      // pulse done for the cycle after rounding
      done <= (state == S_RND);
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r     <= req.op;
            spec     <= spec_n;
            spec_val <= spec_v;
            if (spec_n) begin
              state <= S_RND;
            end else begin
              case (req.op)
                OP_MUL: begin
                  sgn <= sgn_x;
                  if (prod[47]) begin
                    ex  <= e_mul + 10'sd1;
                    man <= {prod[47:22], |prod[21:0]};
                  end else begin
                    ex  <= e_mul;
                    man <= {prod[46:21], |prod[20:0]};
                  end
                  state <= S_RND;
                end
                OP_ADD, OP_SUB: begin
                  sgn   <= big[31];
                  ex    <= $signed({2'b0, e_big});
                  rem   <= {2'b0, sum};
                  state <= S_NORM;
                end
                OP_DIV: begin
                  sgn   <= sgn_x;
                  ex    <= e_div;
                  rem   <= div_lt ? {5'd0, ua.m, 1'b0} : {6'd0, ua.m};
                  dvs   <= ub.m;
                  quo   <= 27'd0;
                  cnt   <= 5'd27;
                  state <= S_RUN;
                end
                OP_SQRT: begin
                  sgn   <= 1'b0;
                  ex    <= e_sq;
                  rad   <= {sq_m, 29'd0};
                  rem   <= 30'd0;
                  quo   <= 27'd0;
                  cnt   <= 5'd27;
                  state <= S_RUN;
                end
                OP_ITOF: begin
                  sgn   <= 1'b0;
                  ex    <= 10'sd159;
                  ival  <= req.ival;
                  state <= S_RUN;
                end
                default: state <= S_RND;
              endcase
            end
          end
        end
        S_RUN: begin
          case (op_r)
            OP_DIV, OP_SQRT: begin
              if (cnt == 5'd0) begin
                man   <= {quo[26:1], quo[0] | (rem != 30'd0)};
                state <= S_RND;
              end else begin
                cnt <= cnt - 5'd1;
                if (op_r == OP_DIV) begin
                  if (rem >= {6'd0, dvs}) begin
                    rem <= {rsub[28:0], 1'b0};
                    quo <= {quo[25:0], 1'b1};
                  end else begin
                    rem <= {rem[28:0], 1'b0};
                    quo <= {quo[25:0], 1'b0};
                  end
                end else begin
                  rad <= {rad[51:0], 2'b00};
                  if (rem2 >= trial) begin
                    rem <= sdiff;
                    quo <= {quo[25:0], 1'b1};
                  end else begin
                    rem <= rem2;
                    quo <= {quo[25:0], 1'b0};
                  end
                end
              end
            end
            OP_ITOF: begin
              if (ival[32]) begin
                man   <= {ival[32:7], |ival[6:0]};
                state <= S_RND;
              end else if (ival[32:25] == 8'd0) begin
                ival <= {ival[24:0], 8'd0};
                ex   <= ex - 10'sd8;
              end else begin
                ival <= {ival[31:0], 1'b0};
                ex   <= ex - 10'sd1;
              end
            end
            default: state <= S_RND;
          endcase
        end
        S_NORM: begin
          if (rem[27]) begin
            man <= {rem[27:2], rem[1] | rem[0]};
            ex  <= ex + 10'sd1;
          end else begin
            man <= rem[26:0] << lz;
            ex  <= ex - $signed({5'd0, lz});
          end
          state <= S_RND;
        end
        S_RND: begin
          result <= spec ? spec_val : fp_round(sgn, ex, man);
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rmms_back.sv =====
// Back end: sequences the float unit over one sample and holds the running statistics.
`timescale 1ns / 1ps
module rmms_back import rmms_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  smp_t        q_item,
  output logic        q_pop,
  output logic        fpu_start,
  output fpu_req_t    fpu_req,
  input  logic        fpu_done,
  input  logic [31:0] fpu_result,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [31:0] mean_value,
  output logic [31:0] max_value,
  output logic [31:0] std_dev_value,
  output logic [31:0] good_count,
  output logic [31:0] rejected_count,
  output logic [31:0] latest_value
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_ISSUE = 2'd1;
  localparam logic [1:0] B_WAIT  = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  // sequencer steps
  localparam logic [3:0] ST_NF    = 4'd0;
  localparam logic [3:0] ST_N1F   = 4'd1;
  localparam logic [3:0] ST_MNF   = 4'd2;
  localparam logic [3:0] ST_ADDX  = 4'd3;
  localparam logic [3:0] ST_MEAN  = 4'd4;
  localparam logic [3:0] ST_DELTA = 4'd5;
  localparam logic [3:0] ST_SS    = 4'd6;
  localparam logic [3:0] ST_T1    = 4'd7;
  localparam logic [3:0] ST_K     = 4'd8;
  localparam logic [3:0] ST_DD    = 4'd9;
  localparam logic [3:0] ST_T2    = 4'd10;
  localparam logic [3:0] ST_SUM   = 4'd11;
  localparam logic [3:0] ST_VAR   = 4'd12;
  localparam logic [3:0] ST_SQRT  = 4'd13;

  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    if (a[31] != b[31]) return !a[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  logic [1:0]            bstate;
  logic [3:0]            step;
  logic                  good;
  logic [31:0]           x;
  logic [31:0]           mean, maxv, sd, latest;
  logic [COUNT_BITS-1:0] cnt, bad;
  logic [31:0]           nf, n1f, nm, d, t1, k, acc;
  logic [32:0]           n33;
  logic                  commit;

  assign q_pop     = (bstate == B_IDLE) && q_valid;
  assign fpu_start = (bstate == B_ISSUE);
  assign n33       = 33'(cnt);
  assign commit    = (bstate == B_DONE) && (!out_valid || out_ready);

  // outputs follow the state, which only moves when the output slot frees
  assign mean_value     = mean;
  assign max_value      = maxv;
  assign std_dev_value  = sd;
  assign good_count     = 32'(cnt);
  assign rejected_count = 32'(bad);
  assign latest_value   = latest;

  always_comb begin
    fpu_req.ival = n33;
    fpu_req.a    = acc;
    fpu_req.b    = acc;
    fpu_req.op   = OP_MUL;
    case (step)
      ST_NF:    fpu_req.op = OP_ITOF;
      ST_N1F: begin
        fpu_req.op   = OP_ITOF;
        fpu_req.ival = n33 + 33'd1;
      end
      ST_MNF: begin
        fpu_req.a = mean;
        fpu_req.b = nf;
      end
      ST_ADDX: begin
        fpu_req.op = OP_ADD;
        fpu_req.b  = x;
      end
      ST_MEAN: begin
        fpu_req.op = OP_DIV;
        fpu_req.b  = n1f;
      end
      ST_DELTA: begin
        fpu_req.op = OP_SUB;
        fpu_req.a  = nm;
        fpu_req.b  = mean;
      end
      ST_SS: begin
        fpu_req.a = sd;
        fpu_req.b = sd;
      end
      ST_T1:    fpu_req.a = nf;
      ST_K: begin
        fpu_req.a = nf;
        fpu_req.b = n1f;
      end
      ST_DD: begin
        fpu_req.a = d;
        fpu_req.b = d;
      end
      ST_T2:    fpu_req.a = k;
      ST_SUM: begin
        fpu_req.op = OP_ADD;
        fpu_req.a  = t1;
      end
      ST_VAR: begin
        fpu_req.op = OP_DIV;
        fpu_req.b  = n1f;
      end
      ST_SQRT:  fpu_req.op = OP_SQRT;
      default:  fpu_req.op = OP_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      step      <= ST_NF;
      mean      <= 32'd0;
      maxv      <= NEG_INF_BITS;
      sd        <= 32'd0;
      latest    <= 32'd0;
      cnt       <= '0;
      bad       <= '0;
      out_valid <= 1'b0;
      accepted  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (bstate)
        B_IDLE: begin
          if (q_valid) begin
            x      <= q_item.bits;
            good   <= q_item.finite;
            step   <= ST_NF;
            bstate <= q_item.finite ? B_ISSUE : B_DONE;
          end
        end
        B_ISSUE: bstate <= B_WAIT;
        B_WAIT: begin
          if (fpu_done) begin
            case (step)
              ST_NF:    nf  <= fpu_result;
              ST_N1F:   n1f <= fpu_result;
              ST_MEAN:  nm  <= fpu_result;
              ST_DELTA: d   <= fpu_result;
              ST_T1:    t1  <= fpu_result;
              ST_K:     k   <= fpu_result;
              default:  acc <= fpu_result;
            endcase
            if (step == ST_SQRT) begin
              bstate <= B_DONE;
            end else begin
              step   <= step + 4'd1;
              bstate <= B_ISSUE;
            end
          end
        end
        B_DONE: begin
          if (commit) begin
            if (good) begin
              mean   <= nm;
              sd     <= acc;
              latest <= x;
              if (fp_gt(x, maxv)) maxv <= x;
              if (cnt != CNT_MAX) cnt <= cnt + COUNT_BITS'(1);
            end else begin
              if (bad != CNT_MAX) bad <= bad + COUNT_BITS'(1);
            end
            accepted <= good;
            bstate   <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/running_mean_max_stddev_top.sv =====
// A non-finite sample passes through the input queue and the back end's done state to
// out_valid with no float step. A finite sample needs fourteen dependent float steps on
// one shared unit, among them two divides and a square root that each develop 27 result
// bits; a zero or special operand lets a step skip straight to rounding. One sample is
// worked at a time; a two-entry queue takes new beats meanwhile.
// Reset (rst, synchronous): mean, deviation and latest to +0, max to -inf, counts to 0.
`timescale 1ns / 1ps
module running_mean_max_stddev_top import rmms_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [31:0] mean_value,
  output logic [31:0] max_value,
  output logic [31:0] std_dev_value,
  output logic [31:0] good_count,
  output logic [31:0] rejected_count,
  output logic [31:0] latest_value
);

  logic        q_valid;
  smp_t        q_item;
  logic        q_pop;
  logic        fpu_start;
  fpu_req_t    fpu_req;
  logic        fpu_done;
  logic [31:0] fpu_result;

  rmms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_bits (sample_bits),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  rmms_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .req    (fpu_req),
    .done   (fpu_done),
    .result (fpu_result)
  );

  rmms_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .fpu_start      (fpu_start),
    .fpu_req        (fpu_req),
    .fpu_done       (fpu_done),
    .fpu_result     (fpu_result),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .mean_value     (mean_value),
    .max_value      (max_value),
    .std_dev_value  (std_dev_value),
    .good_count     (good_count),
    .rejected_count (rejected_count),
    .latest_value   (latest_value)
  );

  a_good_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> good_count >= $past(good_count))
    else $error("good count went backward");

  a_rej_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> rejected_count >= $past(rejected_count))
    else $error("rejected count went backward");

  a_acc_finite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (latest_value[30:23] != 8'hFF && good_count != 32'd0))
    else $error("accepted beat without a finite latest sample");

endmodule

// ===== tb/tb_running_mean_max_stddev_top.sv =====
// Testbench for the running mean, max and standard deviation block.
`timescale 1ns / 1ps
module tb_running_mean_max_stddev_top;
  import rmms_pkg::QNAN_BITS;
  import rmms_pkg::NEG_INF_BITS;

  typedef enum int {FC_ZERO, FC_FIN, FC_INF, FC_NAN} fclass_e;

  typedef struct {
    logic        accepted;
    logic [31:0] mean_value;
    logic [31:0] max_value;
    logic [31:0] std_dev_value;
    logic [31:0] good_count;
    logic [31:0] rejected_count;
    logic [31:0] latest_value;
  } stats_t;

  localparam longint CNT_MAX = (64'd1 << 32) - 1;

  class stats_scoreboard;
    stats_t      pending_stats[$];
    int          errors;
    logic [31:0] mean_q, max_q, std_q, latest_q;
    longint      good_q, bad_q;

    function new();
      errors   = 0;
      mean_q   = 32'h0;
      max_q    = NEG_INF_BITS;
      std_q    = 32'h0;
      latest_q = 32'h0;
      good_q   = 0;
      bad_q    = 0;
    endfunction

    // value = sign * m * 2^e
    function void unpack(input logic [31:0] a, output fclass_e c, output logic s,
                         output logic [23:0] m, output int e);
      s = a[31];
      m = {1'b0, a[22:0]};
      e = -149;
      if (a[30:23] == 8'hFF) c = (a[22:0] != 0) ? FC_NAN : FC_INF;
      else if (a[30:0] == 0) c = FC_ZERO;
      else begin
        c = FC_FIN;
        if (a[30:23] != 0) begin
          m = {1'b1, a[22:0]};
          e = int'(a[30:23]) - 150;
        end
      end
    endfunction

    // round to nearest even; the lowest bit of m may carry a sticky flag
    function logic [31:0] pack(input logic s, input int e, input logic [127:0] m);
      int k, lsb, sh, ex;
      logic [127:0] kp, rem, half;
      if (m == 0) return {s, 31'b0};
      k = 127;
      while (!m[k]) k--;
      lsb = k + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      if (sh <= 0) kp = m << (-sh);
      else if (sh > k + 1) kp = 0;
      else begin
        kp   = m >> sh;
        rem  = m & ((128'b1 << sh) - 1);
        half = 128'b1 << (sh - 1);
        if (rem > half || (rem == half && kp[0])) kp = kp + 1;
      end
      if (kp == (128'b1 << 24)) begin
        kp = kp >> 1;
        lsb++;
      end
      ex = (kp >= (128'b1 << 23)) ? lsb + 150 : 0;
      if (ex >= 255) return {s, 8'hFF, 23'b0};
      return {s, ex[7:0], kp[22:0]};
    endfunction

    function logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      fclass_e ca, cb;
      logic sa, sb;
      logic [23:0] ma, mb;
      int ea, eb;
      unpack(a, ca, sa, ma, ea);
      unpack(b, cb, sb, mb, eb);
      if (ca == FC_NAN || cb == FC_NAN) return QNAN_BITS;
      if ((ca == FC_INF && cb == FC_ZERO) || (ca == FC_ZERO && cb == FC_INF)) return QNAN_BITS;
      if (ca == FC_INF || cb == FC_INF) return {sa ^ sb, 8'hFF, 23'b0};
      return pack(sa ^ sb, ea + eb, 128'(ma) * 128'(mb));
    endfunction

    function logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      fclass_e ca, cb;
      logic sa, sb;
      logic [23:0] ma, mb;
      int ea, eb, d;
      logic [127:0] xa, xb;
      unpack(a, ca, sa, ma, ea);
      unpack(b, cb, sb, mb, eb);
      if (ca == FC_NAN || cb == FC_NAN) return QNAN_BITS;
      if (ca == FC_INF && cb == FC_INF) return (sa != sb) ? QNAN_BITS : a;
      if (ca == FC_INF) return a;
      if (cb == FC_INF) return b;
      if (ca == FC_ZERO && cb == FC_ZERO) return {sa & sb, 31'b0};
      if (ca == FC_ZERO) return b;
      if (cb == FC_ZERO) return a;
      if (ea < eb) return f_add(b, a);
      d  = ea - eb;
      xa = 128'(ma) << 40;
      xb = 128'(mb) << 40;
      // fold shifted-out bits into a sticky lsb
      if (d >= 64) xb = 128'd1;
      else if (d > 0) xb = (xb >> d) | 128'((xb & ((128'b1 << d) - 1)) != 0);
      if (sa == sb) return pack(sa, ea - 40, xa + xb);
      if (xa == xb) return 32'h0;
      if (xa > xb) return pack(sa, ea - 40, xa - xb);
      return pack(sb, ea - 40, xb - xa);
    endfunction

    function logic [31:0] f_sub(input logic [31:0] a, input logic [31:0] b);
      return f_add(a, {~b[31], b[30:0]});
    endfunction

    function logic [31:0] f_div(input logic [31:0] a, input logic [31:0] b);
      fclass_e ca, cb;
      logic sa, sb;
      logic [23:0] ma, mb;
      int ea, eb;
      logic [127:0] q, r;
      unpack(a, ca, sa, ma, ea);
      unpack(b, cb, sb, mb, eb);
      if (ca == FC_NAN || cb == FC_NAN) return QNAN_BITS;
      if ((ca == FC_INF && cb == FC_INF) || (ca == FC_ZERO && cb == FC_ZERO)) return QNAN_BITS;
      if (ca == FC_INF || cb == FC_ZERO) return {sa ^ sb, 8'hFF, 23'b0};
      if (ca == FC_ZERO || cb == FC_INF) return {sa ^ sb, 31'b0};
      q = (128'(ma) << 64) / 128'(mb);
      r = (128'(ma) << 64) % 128'(mb);
      return pack(sa ^ sb, ea - eb - 65, (q << 1) | 128'(r != 0));
    endfunction

    function logic [31:0] f_sqrt(input logic [31:0] a);
      fclass_e ca;
      logic sa;
      logic [23:0] ma;
      int ea;
      logic [127:0] v, res, rem, bitv;
      unpack(a, ca, sa, ma, ea);
      if (ca == FC_NAN) return QNAN_BITS;
      if (ca == FC_ZERO) return a;
      if (sa) return QNAN_BITS;
      if (ca == FC_INF) return a;
      v = 128'(ma);
      if (ea % 2 != 0) begin
        v = v << 1;
        ea--;
      end
      v    = v << 80;
      rem  = v;
      res  = 0;
      bitv = 128'b1 << 126;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return pack(1'b0, (ea - 80) / 2 - 1, (res << 1) | 128'(rem != 0));
    endfunction

    function logic f_gt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka, kb;
      if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
        return 1'b0;
      if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
      ka = a[31] ? ~a : (a | 32'h80000000);
      kb = b[31] ? ~b : (b | 32'h80000000);
      return ka > kb;
    endfunction

    function logic [31:0] canon_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF && a[22:0] != 0) ? QNAN_BITS : a;
    endfunction

    // advance the statistics by one accepted input beat
    function void note_sample(input logic [31:0] u);
      stats_t st;
      logic [31:0] nf, n1f, nm, d, t1, t2, k, v;
      st.accepted = 1'b0;
      if (u[30:23] == 8'hFF) begin
        if (bad_q < CNT_MAX) bad_q++;
      end else begin
        nf  = pack(1'b0, 0, 128'(good_q));
        n1f = pack(1'b0, 0, 128'(good_q + 1));
        nm  = f_div(f_add(f_mul(mean_q, nf), u), n1f);
        if (f_gt(u, max_q)) max_q = u;
        d  = f_sub(nm, mean_q);
        t1 = f_mul(nf, f_mul(std_q, std_q));
        k  = f_mul(nf, n1f);
        t2 = f_mul(k, f_mul(d, d));
        v  = f_div(f_add(t1, t2), n1f);
        std_q    = f_sqrt(canon_nan(v));
        mean_q   = canon_nan(nm);
        latest_q = u;
        if (good_q < CNT_MAX) good_q++;
        st.accepted = 1'b1;
      end
      st.mean_value     = mean_q;
      st.max_value      = max_q;
      st.std_dev_value  = std_q;
      st.good_count     = good_q[31:0];
      st.rejected_count = bad_q[31:0];
      st.latest_value   = latest_q;
      pending_stats.push_back(st);
    endfunction

    function void mismatch(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_stats(input stats_t got);
      stats_t want;
      if (pending_stats.size() == 0) begin
        $display("%0t: result beat with nothing pending: expected none, actual mean %h",
                 $time, got.mean_value);
        errors++;
        return;
      end
      want = pending_stats.pop_front();
      if (got.accepted !== want.accepted) mismatch("accepted", 32'(want.accepted), 32'(got.accepted));
      if (got.mean_value !== want.mean_value) mismatch("mean", want.mean_value, got.mean_value);
      if (got.max_value !== want.max_value) mismatch("max", want.max_value, got.max_value);
      if (got.std_dev_value !== want.std_dev_value)
        mismatch("std_dev", want.std_dev_value, got.std_dev_value);
      if (got.good_count !== want.good_count) mismatch("good_count", want.good_count, got.good_count);
      if (got.rejected_count !== want.rejected_count)
        mismatch("rejected_count", want.rejected_count, got.rejected_count);
      if (got.latest_value !== want.latest_value)
        mismatch("latest", want.latest_value, got.latest_value);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] sample_bits;
  logic        out_valid;
  logic        out_ready;
  logic        accepted;
  logic [31:0] mean_value, max_value, std_dev_value;
  logic [31:0] good_count, rejected_count, latest_value;

  stats_scoreboard sb = new();
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  beats_sent     = 0;
  logic hold_off      = 1'b0;

  running_mean_max_stddev_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // sink side: check each result beat, then pick next ready
  initial begin
    stats_t got;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.accepted       = accepted;
        got.mean_value     = mean_value;
        got.max_value      = max_value;
        got.std_dev_value  = std_dev_value;
        got.good_count     = good_count;
        got.rejected_count = rejected_count;
        got.latest_value   = latest_value;
        sb.check_stats(got);
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long sink hold-off so the input queue fills and stalls
  initial begin
    wait (beats_sent >= 250);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (1500) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_sample(input logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_bits <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x);
    beats_sent++;
  endtask

  function automatic logic [31:0] random_sample();
    int r;
    r = $urandom_range(99);
    if (r < 5) return {1'($urandom), 8'hFF, 23'($urandom)};
    if (r < 8) return {1'($urandom), 8'h00, 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(155, 100)), 23'($urandom)};
  endfunction

  initial begin
    logic [31:0] head[$];
    logic [31:0] tail[$];
    head = '{32'h80000000, 32'h00000000, 32'h00000001, 32'h807FFFFF, 32'h00800000,
             32'h3F800000, 32'hC0200000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
             32'h7F800001, 32'hFFFFFFFF, 32'h41200000, 32'h3F800000, 32'hBF800000};
    // huge magnitudes last: their overflow poisons mean and deviation for good
    tail = '{32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F000000, 32'hFF800000, 32'h00400000,
             32'h7F7FFFFF, 32'h3F800000};
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample_bits = 32'h0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (head[i]) send_sample(head[i]);
    for (int i = 0; i < 830; i++) begin
      case ((i / 100) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      send_sample(random_sample());
    end
    foreach (tail[i]) send_sample(tail[i]);
    in_valid <= 1'b0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
